### rtl/core/ssc_pkg.sv
// Shared types and constants for the scaled sample change reporter.
// No dependencies; every other file in rtl/core refers to this package.
package ssc_pkg;

  // Configuration register widths, indexes and reset values
  localparam int OUT_SPAN_W = 10;
  localparam int IN_SPAN_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_SPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_SPAN  = 2'd1;

  localparam logic [OUT_SPAN_W-1:0] OUT_SPAN_RESET = 10'd150;
  localparam logic [IN_SPAN_W-1:0]  IN_SPAN_RESET  = 12'd308;

  // Reading and decimal form
  localparam int READING_W  = 16;
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam logic [READING_W-1:0] READING_MAX = 16'hFFFF;

  // Report line characters
  localparam int                  PREFIX_LEN  = 5;
  localparam logic [7:0]          ASCII_ZERO  = 8'h30;
  localparam logic [7:0]          ASCII_CR    = 8'h0D;
  localparam logic [7:0]          ASCII_LF    = 8'h0A;

  // Byte source select for the output register
  localparam logic [1:0] BYTE_PRE = 2'd0;
  localparam logic [1:0] BYTE_DIG = 2'd1;
  localparam logic [1:0] BYTE_CR  = 2'd2;
  localparam logic [1:0] BYTE_LF  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       div_step;
    logic       judge;
    logic       dab_step;
    logic       trim_step;
    logic       emit;
    logic [1:0] byte_sel;
  } ssc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic changed;
    logic dab_last;
    logic lead_zero;
    logic pre_last;
    logic dig_last;
    logic out_free;
  } ssc_sts_t;

  // Characters of the "temp=" prefix
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h74; // t
      3'd1:    ch = 8'h65; // e
      3'd2:    ch = 8'h6D; // m
      3'd3:    ch = 8'h70; // p
      3'd4:    ch = 8'h3D; // =
      default: ch = 8'h3D;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/scaled_sample_change_reporter.sv
// Top level of the scaled sample change reporter.
// Depends on ssc_pkg, ssc_ctrl and ssc_datapath.
//
//   Channel  Ports                               Direction  Payload
//   in       in_valid / in_stall                 input      in_adc_sample
//   out      out_valid / out_stall               output     out_tx_byte, out_last_byte
//   cfg      cfg_we, cfg_index, cfg_wdata        input      out_span (0), in_span (1)
//
// An item that leaves the reading unchanged goes through load, multiply, the
// one-bit-per-cycle divider and the compare; a new reading adds the
// binary-to-BCD conversion, the zero trim and the report bytes (each
// dropped digit costs one trim step and saves one report byte).
// out_stall holds the byte sequencer; the final line feed may wait in the
// output register while the next sample is taken. Reset is synchronous.
module scaled_sample_change_reporter #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_last_byte
);

  ssc_pkg::ssc_cmd_t cmd;
  ssc_pkg::ssc_sts_t sts;

  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_adc_sample (in_adc_sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

### rtl/core/ssc_ctrl.sv
// Sequencing state machine for the scaled sample change reporter.
// Depends on ssc_pkg for the command and status structs and byte selects.
module ssc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssc_pkg::ssc_sts_t sts,
  output ssc_pkg::ssc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_JUDGE = 4'd3;
  localparam logic [3:0] S_DAB   = 4'd4;
  localparam logic [3:0] S_TRIM  = 4'd5;
  localparam logic [3:0] S_PRE   = 4'd6;
  localparam logic [3:0] S_DIG   = 4'd7;
  localparam logic [3:0] S_CR    = 4'd8;
  localparam logic [3:0] S_LF    = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Take a new sample only when idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.byte_sel  = ssc_pkg::BYTE_PRE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_nxt = sts.changed ? S_DAB : S_IDLE;
      end
      S_DAB: begin
        cmd.dab_step = 1'b1;
        if (sts.dab_last) state_nxt = S_TRIM;
      end
      S_TRIM: begin
        if (sts.lead_zero) begin
          cmd.trim_step = 1'b1;
        end else begin
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.byte_sel = ssc_pkg::BYTE_PRE;
          if (sts.pre_last) state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.byte_sel = ssc_pkg::BYTE_DIG;
          if (sts.dig_last) state_nxt = S_CR;
        end
      end
      S_CR: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.byte_sel = ssc_pkg::BYTE_CR;
          state_nxt    = S_LF;
        end
      end
      S_LF: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.byte_sel = ssc_pkg::BYTE_LF;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ssc_datapath.sv
// Datapath: config registers, scale multiply, serial divider, binary to BCD
// converter, digit trim and the output byte register. Depends on ssc_pkg.
module ssc_datapath #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]                in_adc_sample,
  input  ssc_pkg::ssc_cmd_t                     cmd,
  output ssc_pkg::ssc_sts_t                     sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_tx_byte,
  output logic                                  out_last_byte
);

  localparam int PW  = SAMPLE_BITS + ssc_pkg::OUT_SPAN_W;
  localparam int DCW = $clog2(PW);
  localparam int RW  = ssc_pkg::READING_W;
  localparam int BW  = ssc_pkg::BCD_W;
  localparam int SW  = ssc_pkg::IN_SPAN_W;

  // Control registers
  logic [ssc_pkg::OUT_SPAN_W-1:0] out_span_r, out_span_nxt;
  logic [SW-1:0]                  in_span_r, in_span_nxt;
  logic [RW-1:0]                  last_r, last_nxt;
  logic [DCW-1:0]                 div_cnt_r, div_cnt_nxt;
  logic [3:0]                     dab_cnt_r, dab_cnt_nxt;
  logic [2:0]                     ndig_r, ndig_nxt;
  logic [2:0]                     pre_cnt_r, pre_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // Payload registers
  logic [SAMPLE_BITS-1:0]         sample_r, sample_nxt;
  logic [PW-1:0]                  quo_r, quo_nxt;
  logic [SW-1:0]                  rem_r, rem_nxt;
  logic [RW-1:0]                  bin_r, bin_nxt;
  logic [BW-1:0]                  bcd_r, bcd_nxt;
  logic [7:0]                     tx_byte_r, tx_byte_nxt;
  logic                           last_byte_r, last_byte_nxt;

  logic [PW-1:0]                  prod;
  logic [SW:0]                    rem_sh;
  logic [SW:0]                    rem_diff;
  logic                           q_bit;
  logic [RW-1:0]                  reading;
  logic [BW-1:0]                  bcd_adj;

  // Scale product, one multiply per item
  assign prod = PW'(sample_r) * PW'(out_span_r);

  // Restoring divide step: one quotient bit per cycle
  assign rem_sh   = {rem_r, quo_r[PW-1]};
  assign q_bit    = (rem_sh >= {1'b0, in_span_r});
  assign rem_diff = rem_sh - {1'b0, in_span_r};

  // Saturate on zero span or an oversized quotient
  assign reading = ((in_span_r == '0) || (quo_r[PW-1:RW] != '0)) ?
                   ssc_pkg::READING_MAX : quo_r[RW-1:0];

  // Add-three correction for each BCD digit
  always_comb begin
    for (int d = 0; d < ssc_pkg::NUM_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ?
                          (bcd_r[4*d +: 4] + 4'd3) : bcd_r[4*d +: 4];
    end
  end

  // Status to controller
  always_comb begin
    sts.div_last  = (div_cnt_r == DCW'(PW - 1));
    sts.changed   = (reading != last_r);
    sts.dab_last  = (dab_cnt_r == 4'd15);
    sts.lead_zero = (bcd_r[BW-1 -: 4] == 4'd0) && (ndig_r > 3'd1);
    sts.pre_last  = (pre_cnt_r == 3'(ssc_pkg::PREFIX_LEN - 1));
    sts.dig_last  = (ndig_r == 3'd1);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Next values
  always_comb begin
    out_span_nxt  = out_span_r;
    in_span_nxt   = in_span_r;
    last_nxt      = last_r;
    div_cnt_nxt   = div_cnt_r;
    dab_cnt_nxt   = dab_cnt_r;
    ndig_nxt      = ndig_r;
    pre_cnt_nxt   = pre_cnt_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    tx_byte_nxt   = tx_byte_r;
    last_byte_nxt = last_byte_r;

    // Configuration writes; unknown indexes drop
    if (cfg_we) begin
      if (cfg_index == ssc_pkg::REG_OUT_SPAN) begin
        out_span_nxt = cfg_wdata[ssc_pkg::OUT_SPAN_W-1:0];
      end else if (cfg_index == ssc_pkg::REG_IN_SPAN) begin
        in_span_nxt = cfg_wdata[SW-1:0];
      end
    end

    if (cmd.load) begin
      sample_nxt  = in_adc_sample;
      div_cnt_nxt = '0;
    end

    if (cmd.mul) begin
      quo_nxt = prod;
      rem_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt     = q_bit ? rem_diff[SW-1:0] : rem_sh[SW-1:0];
      quo_nxt     = {quo_r[PW-2:0], q_bit};
      div_cnt_nxt = div_cnt_r + 1'b1;
    end

    // Compare with the last report and set up the conversion
    if (cmd.judge) begin
      if (sts.changed) last_nxt = reading;
      bin_nxt     = reading;
      bcd_nxt     = '0;
      dab_cnt_nxt = '0;
      ndig_nxt    = 3'(ssc_pkg::NUM_DIGITS);
      pre_cnt_nxt = '0;
    end

    if (cmd.dab_step) begin
      {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
      dab_cnt_nxt        = dab_cnt_r + 1'b1;
    end

    // Drop a leading zero digit
    if (cmd.trim_step) begin
      bcd_nxt  = bcd_r << 4;
      ndig_nxt = ndig_r - 1'b1;
    end

    // Load the output register, or clear it once taken
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      last_byte_nxt = 1'b0;
      unique case (cmd.byte_sel)
        ssc_pkg::BYTE_PRE: begin
          tx_byte_nxt = ssc_pkg::prefix_char(pre_cnt_r);
          pre_cnt_nxt = pre_cnt_r + 1'b1;
        end
        ssc_pkg::BYTE_DIG: begin
          tx_byte_nxt = ssc_pkg::ASCII_ZERO | {4'd0, bcd_r[BW-1 -: 4]};
          bcd_nxt     = bcd_r << 4;
          ndig_nxt    = ndig_r - 1'b1;
        end
        ssc_pkg::BYTE_CR: begin
          tx_byte_nxt = ssc_pkg::ASCII_CR;
        end
        ssc_pkg::BYTE_LF: begin
          tx_byte_nxt   = ssc_pkg::ASCII_LF;
          last_byte_nxt = 1'b1;
        end
        default: tx_byte_nxt = ssc_pkg::ASCII_LF;
      endcase
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_span_r  <= ssc_pkg::OUT_SPAN_RESET;
      in_span_r   <= ssc_pkg::IN_SPAN_RESET;
      last_r      <= '0;
      div_cnt_r   <= '0;
      dab_cnt_r   <= '0;
      ndig_r      <= 3'(ssc_pkg::NUM_DIGITS);
      pre_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_span_r  <= out_span_nxt;
      in_span_r   <= in_span_nxt;
      last_r      <= last_nxt;
      div_cnt_r   <= div_cnt_nxt;
      dab_cnt_r   <= dab_cnt_nxt;
      ndig_r      <= ndig_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    tx_byte_r   <= tx_byte_nxt;
    last_byte_r <= last_byte_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_last_byte = last_byte_r;

  // Never overwrite a byte that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("byte loaded while output register busy");

  // The count reaches zero once the last digit has gone out
  a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ndig_r <= 3'(ssc_pkg::NUM_DIGITS)))
    else $error("digit count out of range");

  a_last_update: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.judge && sts.changed) |=> (last_r == $past(reading)))
    else $error("last reported reading not updated");

  a_lf_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> (out_tx_byte == ssc_pkg::ASCII_LF))
    else $error("last byte flag on a byte other than line feed");

endmodule
